FILE: sv/rsc_pkg.sv
// shared widths, fixed-point constants and the pipeline stage record
// for the richardson stability correction block; no dependencies
package rsc_pkg;

  localparam int ZW = 24;  // heights, Q8.16
  localparam int TW = 16;  // temperatures, Q8.8
  localparam int WW = 16;  // wind, Q8.8
  localparam int CW = 18;  // correction, Q2.16

  localparam int NSTAGE = 64;

  localparam logic [20:0] G2_Q16   = 21'd1285816;  // 2 * 9.81 in Q16
  localparam logic [17:0] TK2_Q8   = 18'd139852;   // 2 * 273.15 in Q8
  localparam logic [17:0] TK_Q8    = 18'd69926;
  localparam logic [15:0] LN2_Q16  = 16'd45426;
  localparam logic [21:0] FIVE_Q16 = 22'd327680;
  localparam logic [17:0] ONE_Q16  = 18'd65536;
  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic [17:0] CORR_MAX = 18'h3FFFF;

  typedef struct packed {
    logic               bad;
    logic               same;
    logic               pos;
    logic [ZW-1:0]      h;
    logic [ZW-1:0]      z0;
    logic signed [15:0] ta;
    logic [17:0]        tsum;
    logic [36:0]        a;
    logic [31:0]        ww;
    logic [60:0]        num1;
    logic [49:0]        den1;
    logic               cap1;
    logic [49:0]        r1;
    logic [23:0]        lo1;
    logic [23:0]        q1;
    logic [30:0]        mh;
    logic [30:0]        mz;
    logic [20:0]        lh;
    logic [20:0]        lz;
    logic [20:0]        lq;
    logic [38:0]        den2;
    logic               cap2;
    logic [39:0]        r2;
    logic [23:0]        q2;
    logic               rp;
    logic [26:0]        tabs;
    logic [35:0]        sv;
    logic [52:0]        sq;
    logic [17:0]        csq;
    logic [19:0]        rem;
    logic [17:0]        root;
    logic [CW-1:0]      corr;
  } pipe_t;

endpackage

FILE: sv/rsc_if.sv
// valid/ready channel interfaces for the input and result items
// depends on rsc_pkg for field widths
interface rsc_in_if;
  import rsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ZW-1:0]      ref_height;
  logic [ZW-1:0]      displacement;
  logic signed [TW-1:0] surface_temp;
  logic signed [TW-1:0] air_temp;
  logic [WW-1:0]      wind_speed;
  logic [ZW-1:0]      roughness;
  modport source (output valid, ref_height, displacement, surface_temp, air_temp,
                  wind_speed, roughness, input ready);
  modport sink (input valid, ref_height, displacement, surface_temp, air_temp,
                wind_speed, roughness, output ready);
endinterface

interface rsc_out_if;
  import rsc_pkg::*;
  logic          valid;
  logic          ready;
  logic [CW-1:0] correction;
  logic          invalid;
  modport source (output valid, correction, invalid, input ready);
  modport sink (input valid, correction, invalid, output ready);
endinterface

FILE: sv/richardson_stability_correction.sv
// throughput one item per cycle while the output register is not waiting on ready
// the whole pipeline advances together and holds while the output register waits
// longest chains: two 24-step restoring dividers and two 16-step log2 squarings
// rst (synchronous) clears all stage valid bits; payload registers are not reset
// depends on rsc_pkg and rsc_if
module richardson_stability_correction (
  input  logic      clk,
  input  logic      rst,
  rsc_in_if.sink    in_item,
  rsc_out_if.source out_item
);
  import rsc_pkg::*;

  localparam int S_LOG0 = 2;   // log squarings in stages 2..17
  localparam int S_MUL  = 2;
  localparam int S_DIVI = 3;
  localparam int S_RD0  = 4;   // ri divider steps 4..27
  localparam int S_LQ   = 18;
  localparam int S_DEN2 = 19;
  localparam int S_RL0  = 20;
  localparam int S_RS0  = 21;  // limit divider steps 21..44
  localparam int S_RI   = 45;
  localparam int S_SQ   = 46;
  localparam int S_RND  = 47;
  localparam int S_RT0  = 46;  // sqrt steps 46..63

  function automatic logic [4:0] msb24(logic [ZW-1:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < ZW; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  // one squaring step of the Q1.30 mantissa; top bit is the result bit
  function automatic logic [31:0] log_step(logic [30:0] m);
    logic [61:0] p;
    logic [31:0] m2;
    p  = m * m;
    m2 = p[61:30];
    if (m2[31]) return {1'b1, m2[31:1]};
    else return {1'b0, m2[30:0]};
  endfunction

  pipe_t           pipe [1:NSTAGE];
  logic [NSTAGE:1] vld;
  logic            adv;

  assign adv            = !vld[NSTAGE] || out_item.ready;
  assign in_item.ready  = adv;
  assign out_item.valid = vld[NSTAGE];
  assign out_item.correction = pipe[NSTAGE].corr;
  assign out_item.invalid    = pipe[NSTAGE].bad;

  // stage 1: geometry check, temperature terms, first products, log normalize
  pipe_t              d1;
  logic signed [24:0] hs;
  logic signed [16:0] dt;
  logic [15:0]        dtabs;
  logic signed [18:0] tsum_s;
  logic [4:0]         ph, pz;
  always_comb begin
    d1     = '0;
    hs     = $signed({1'b0, in_item.ref_height}) - $signed({1'b0, in_item.displacement});
    d1.bad = (in_item.roughness == '0) || (hs <= $signed({1'b0, in_item.roughness}));
    d1.h   = hs[23:0];
    d1.z0  = in_item.roughness;
    d1.ta  = in_item.air_temp;
    d1.same = (in_item.air_temp == in_item.surface_temp);
    d1.pos  = (in_item.air_temp > in_item.surface_temp);
    dt      = 17'(in_item.air_temp) - 17'(in_item.surface_temp);
    dtabs   = dt[16] ? 16'(-dt) : dt[15:0];
    tsum_s  = 19'(in_item.air_temp) + 19'(in_item.surface_temp) + $signed({1'b0, TK2_Q8});
    d1.tsum = tsum_s[17:0];
    d1.a    = 37'(G2_Q16 * dtabs);
    d1.ww   = in_item.wind_speed * in_item.wind_speed;
    ph      = msb24(hs[23:0]);
    pz      = msb24(in_item.roughness);
    d1.mh   = 31'({7'b0, hs[23:0]} << (5'd30 - ph));
    d1.mz   = 31'({7'b0, in_item.roughness} << (5'd30 - pz));
    d1.lh   = {ph, 16'b0};
    d1.lz   = {pz, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else if (adv) begin
      vld[1] <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[1] <= d1;
    end
  end

  for (genvar s = 2; s <= NSTAGE; s++) begin : g_st
    localparam int LB = (s >= S_LOG0 && s < S_LOG0 + 16) ? 15 - (s - S_LOG0) : 0;
    pipe_t              nx;
    logic [31:0]        lsh, lsz;
    logic [50:0]        rx1, rd1;
    logic [40:0]        rx2, rd2;
    logic signed [21:0] dd;
    logic [20:0]        dc;
    logic [36:0]        lp;
    logic [21:0]        lsum;
    logic [17:0]        n2;
    logic [24:0]        mag, rl;
    logic signed [25:0] ri;
    logic signed [27:0] t;
    logic signed [28:0] u;
    logic [53:0]        rs;
    logic [21:0]        rx3, tst, rd3;

    always_comb begin
      nx   = pipe[s-1];
      lsh  = '0;
      lsz  = '0;
      rx1  = '0;
      rd1  = '0;
      rx2  = '0;
      rd2  = '0;
      dd   = '0;
      dc   = '0;
      lp   = '0;
      lsum = '0;
      n2   = '0;
      mag  = '0;
      rl   = '0;
      ri   = '0;
      t    = '0;
      u    = '0;
      rs   = '0;
      rx3  = '0;
      tst  = '0;
      rd3  = '0;
      if (s >= S_LOG0 && s < S_LOG0 + 16) begin
        lsh       = log_step(pipe[s-1].mh);
        lsz       = log_step(pipe[s-1].mz);
        nx.mh     = lsh[30:0];
        nx.mz     = lsz[30:0];
        nx.lh[LB] = lsh[31];
        nx.lz[LB] = lsz[31];
      end
      if (s == S_MUL) begin
        nx.num1 = 61'(pipe[s-1].a * pipe[s-1].h);
        nx.den1 = 50'(pipe[s-1].ww * pipe[s-1].tsum);
      end
      if (s == S_DIVI) begin
        nx.cap1 = {5'b0, pipe[s-1].num1} >= {pipe[s-1].den1, 16'b0};
        nx.r1   = {5'b0, pipe[s-1].num1[60:16]};
        nx.lo1  = {pipe[s-1].num1[15:0], 8'b0};
        nx.q1   = '0;
      end
      if (s >= S_RD0 && s < S_RD0 + 24) begin
        rx1    = {pipe[s-1].r1, pipe[s-1].lo1[23]};
        rd1    = rx1 - {1'b0, pipe[s-1].den1};
        nx.r1  = (rx1 >= {1'b0, pipe[s-1].den1}) ? rd1[49:0] : rx1[49:0];
        nx.q1  = {pipe[s-1].q1[22:0], rx1 >= {1'b0, pipe[s-1].den1}};
        nx.lo1 = {pipe[s-1].lo1[22:0], 1'b0};
      end
      if (s == S_LQ) begin
        dd    = $signed({1'b0, pipe[s-1].lh}) - $signed({1'b0, pipe[s-1].lz});
        dc    = dd[21] ? '0 : dd[20:0];
        lp    = dc * LN2_Q16;
        nx.lq = lp[36:16];
      end
      if (s == S_DEN2) begin
        lsum    = {1'b0, pipe[s-1].lq} + FIVE_Q16;
        nx.den2 = 39'(pipe[s-1].tsum * lsum[20:0]);
      end
      if (s == S_RL0) begin
        n2      = 18'((18'(pipe[s-1].ta) + TK_Q8) << 1);
        nx.cap2 = {5'b0, n2, 16'b0} >= pipe[s-1].den2;
        nx.r2   = {6'b0, n2, 16'b0};
        nx.q2   = '0;
      end
      if (s >= S_RS0 && s < S_RS0 + 24) begin
        rx2   = {pipe[s-1].r2, 1'b0};
        rd2   = rx2 - {2'b0, pipe[s-1].den2};
        nx.r2 = (rx2 >= {2'b0, pipe[s-1].den2}) ? rd2[39:0] : rx2[39:0];
        nx.q2 = {pipe[s-1].q2[22:0], rx2 >= {2'b0, pipe[s-1].den2}};
      end
      if (s == S_RI) begin
        mag = pipe[s-1].cap1 ? ONE_Q24 : {1'b0, pipe[s-1].q1};
        ri  = pipe[s-1].pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
        rl  = pipe[s-1].cap2 ? ONE_Q24 : {1'b0, pipe[s-1].q2};
        if (ri > $signed({1'b0, rl})) ri = $signed({1'b0, rl});
        nx.rp   = (ri > 26'sd0);
        t       = 28'sd16777216 - 28'(ri) * 28'sd5;
        nx.tabs = t[27] ? 27'(-t) : t[26:0];
        if (ri < -26'sd8388608) ri = -26'sd8388608;
        u       = 29'sd16777216 - 29'(ri) * 29'sd16;
        nx.sv   = {u[27:0], 8'b0};
        nx.rem  = '0;
        nx.root = '0;
      end
      if (s == S_SQ) begin
        nx.sq = 53'(pipe[s-1].tabs * pipe[s-1].tabs);
      end
      if (s == S_RND) begin
        rs     = {1'b0, pipe[s-1].sq} + 54'h80000000;
        nx.csq = (rs[53:32] > {4'b0, CORR_MAX}) ? CORR_MAX : rs[49:32];
      end
      if (s >= S_RT0 && s < S_RT0 + 18) begin
        rx3     = {pipe[s-1].rem, pipe[s-1].sv[35:34]};
        tst     = {2'b0, pipe[s-1].root, 2'b01};
        rd3     = rx3 - tst;
        nx.rem  = (rx3 >= tst) ? rd3[19:0] : rx3[19:0];
        nx.root = {pipe[s-1].root[16:0], rx3 >= tst};
        nx.sv   = {pipe[s-1].sv[33:0], 2'b0};
      end
      if (s == NSTAGE) begin
        if (pipe[s-1].bad || pipe[s-1].same) nx.corr = ONE_Q16;
        else if (pipe[s-1].rp) nx.corr = pipe[s-1].csq;
        else nx.corr = pipe[s-1].root;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[s] <= nx;
      end
    end
  end

endmodule
